/* src/pfs_pkg.sv */
// Package for the Phong fragment shading core: payload structs, fixed-point
// widths and shading constants. No dependencies.
package pfs_pkg;

  // Fixed-point constants
  localparam int ONE_Q14    = 16384;
  localparam int Q14_SH     = 14;
  localparam int SPEC_W_Q14 = 9830;
  localparam int AMBIENT    = 5;
  localparam int CH_MAX     = 255;

  // Datapath widths
  localparam int T_W        = 22;            // transformed / reflected vector lane
  localparam int N_W        = 16;            // unit vector lane, Q1.14
  localparam int S_W        = 2 * T_W;       // sum of squares
  localparam int R_W        = S_W / 2;       // square root
  localparam int RM_W       = R_W + 2;       // square root remainder
  localparam int SQRT_STEPS = S_W / 2;
  localparam int Q_W        = 15;            // quotient bits, covers 1.0
  localparam int DV_W       = T_W + Q14_SH;  // dividend
  localparam int D_W        = 18;            // n.l in Q3.14
  localparam int ACC_W      = 15;            // specular power accumulator
  localparam int EXP_W      = 8;
  localparam int POW_STEPS  = (1 << EXP_W) - 1;
  localparam int SUM_W      = D_W + 1;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef enum logic [1:0] {
    CFG_ROW0  = 2'd0,
    CFG_ROW1  = 2'd1,
    CFG_ROW2  = 2'd2,
    CFG_LIGHT = 2'd3
  } pfs_cfg_idx_t;

  typedef logic [3:0][15:0] pfs_row_t;
  typedef pfs_row_t [2:0]   pfs_mat_t;
  typedef logic [2:0][15:0] pfs_light_t;

  typedef struct packed {
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic [7:0]         diffuse_red;
    logic [7:0]         diffuse_green;
    logic [7:0]         diffuse_blue;
    logic [7:0]         spec_exponent;
  } pfs_in_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
  } pfs_out_t;

  typedef struct packed {
    logic signed [T_W-1:0] x;
    logic signed [T_W-1:0] y;
    logic signed [T_W-1:0] z;
  } pfs_tvec_t;

  typedef struct packed {
    logic signed [N_W-1:0] x;
    logic signed [N_W-1:0] y;
    logic signed [N_W-1:0] z;
  } pfs_nvec_t;

  typedef struct packed {
    logic [D_W-1:0]   diff;
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic [EXP_W-1:0] expo;
  } pfs_side_t;

  typedef struct packed {
    pfs_tvec_t vec;
    pfs_side_t side;
  } pfs_fq_t;

endpackage

/* src/phong_fragment_shade_core.sv */
// Phong fragment shading core: configuration registers, front, queue, back.
// Throughput: one fragment per cycle unless the queue fills or out_stall holds
// the back part; the specular power pipeline (one multiply per exponent step,
// 255 stages) sets the depth.
// Reset: synchronous active-low rst_n clears all valid bits and loads the
// identity matrix and light (0,0,1); configuration writes are always accepted.
module phong_fragment_shade_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  pfs_pkg::pfs_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output pfs_pkg::pfs_out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [63:0]       cfg_data
);
  import pfs_pkg::*;

  pfs_mat_t   rows_r;
  pfs_light_t light_r;

  assign cfg_ready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r[0]  <= 64'd4096;
      rows_r[1]  <= 64'd4096 << 16;
      rows_r[2]  <= 64'd4096 << 32;
      light_r[0] <= '0;
      light_r[1] <= '0;
      light_r[2] <= 16'(ONE_Q14);
    end else if (cfg_valid && cfg_ready) begin
      unique case (pfs_cfg_idx_t'(cfg_index))
        CFG_ROW0:  rows_r[0] <= cfg_data;
        CFG_ROW1:  rows_r[1] <= cfg_data;
        CFG_ROW2:  rows_r[2] <= cfg_data;
        CFG_LIGHT: light_r   <= cfg_data[47:0];
        default:   rows_r    <= rows_r;
      endcase
    end
  end

  logic    q_full, q_empty, q_push, q_pop;
  pfs_fq_t q_in, q_out;

  pfs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .rows      (rows_r),
    .q_full    (q_full),
    .push      (q_push),
    .push_data (q_in)
  );

  pfs_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .pop_data  (q_out)
  );

  pfs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .pop       (q_pop),
    .q_data    (q_out),
    .light     (light_r),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

/* src/pfs_fifo.sv */
// Short queue between the front and back parts of the shading core.
// Depends on pfs_pkg.
module pfs_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  pfs_pkg::pfs_fq_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output pfs_pkg::pfs_fq_t pop_data
);
  import pfs_pkg::*;

  pfs_fq_t              mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_r, rd_r;
  logic [FIFO_AW:0]     cnt_r, cnt_nxt;

  assign full     = (cnt_r == (FIFO_AW+1)'(FIFO_DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = mem_r[rd_r];

  // track fill level
  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wr_r <= wr_r + 1'b1;
      if (pop)  rd_r <= rd_r + 1'b1;
    end
  end

  // store entry
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_data;
  end

endmodule

/* src/pfs_front.sv */
// Front part: accepts fragments and transforms the normal by the matrix rows.
// Depends on pfs_pkg; feeds pfs_fifo.
module pfs_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  pfs_pkg::pfs_in_t in_data,
  input  pfs_pkg::pfs_mat_t rows,
  input  logic             q_full,
  output logic             push,
  output pfs_pkg::pfs_fq_t push_data
);
  import pfs_pkg::*;

  logic              ce;
  logic              v0_r, v1_r, v2_r;
  pfs_in_t           in_r;
  pfs_side_t         side1_r;
  logic signed [31:0] prod_r [3][3];
  logic signed [15:0] nl [3];
  logic signed [31:0] prod [3][3];
  logic signed [33:0] acc [3];
  pfs_fq_t           out_r;

  // advance while the last stage is empty or can transfer into the queue
  assign ce        = !v2_r || !q_full;
  assign in_stall  = !ce;
  assign push      = v2_r && !q_full;
  assign push_data = out_r;

  always_comb begin
    nl[0] = in_r.normal_x;
    nl[1] = in_r.normal_y;
    nl[2] = in_r.normal_z;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        prod[i][j] = $signed(rows[i][j]) * nl[j];
      end
    end
    for (int i = 0; i < 3; i++) begin
      acc[i] = $signed({rows[i][3], 14'b0}) + prod_r[i][0] + prod_r[i][1] + prod_r[i][2];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (ce) begin
      v0_r <= in_valid;
      v1_r <= v0_r;
      v2_r <= v1_r;
    end
  end

  // capture, multiply, sum and floor-shift into Q7.14
  always_ff @(posedge clk) begin
    if (ce) begin
      in_r <= in_data;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          prod_r[i][j] <= prod[i][j];
        end
      end
      side1_r.diff  <= '0;
      side1_r.red   <= in_r.diffuse_red;
      side1_r.green <= in_r.diffuse_green;
      side1_r.blue  <= in_r.diffuse_blue;
      side1_r.expo  <= in_r.spec_exponent;
      out_r.vec.x   <= acc[0][33:12];
      out_r.vec.y   <= acc[1][33:12];
      out_r.vec.z   <= acc[2][33:12];
      out_r.side    <= side1_r;
    end
  end

endmodule

/* src/pfs_norm.sv */
// Pipelined vector normalizer: squared length, one root bit per stage,
// one quotient bit per stage. Depends on pfs_pkg.
module pfs_norm (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               ce,
  input  logic               in_valid,
  input  pfs_pkg::pfs_tvec_t in_vec,
  input  pfs_pkg::pfs_side_t in_side,
  output logic               out_valid,
  output pfs_pkg::pfs_nvec_t out_vec,
  output pfs_pkg::pfs_side_t out_side
);
  import pfs_pkg::*;

  // square stage
  logic                  v0_r;
  pfs_tvec_t             vec0_r;
  pfs_side_t             side0_r;
  logic [S_W-1:0]        sqx_r, sqy_r, sqz_r;
  logic signed [S_W-1:0] sqx, sqy, sqz;

  always_comb begin
    sqx = in_vec.x * in_vec.x;
    sqy = in_vec.y * in_vec.y;
    sqz = in_vec.z * in_vec.z;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v0_r <= 1'b0;
    else if (ce) v0_r <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      vec0_r  <= in_vec;
      side0_r <= in_side;
      sqx_r   <= sqx;
      sqy_r   <= sqy;
      sqz_r   <= sqz;
    end
  end

  // square root stages
  logic             sq_v_r    [0:SQRT_STEPS];
  logic [S_W-1:0]   sq_s_r    [0:SQRT_STEPS];
  logic [R_W-1:0]   sq_root_r [0:SQRT_STEPS];
  logic [RM_W-1:0]  sq_rem_r  [0:SQRT_STEPS];
  pfs_tvec_t        sq_vec_r  [0:SQRT_STEPS];
  pfs_side_t        sq_side_r [0:SQRT_STEPS];

  always_ff @(posedge clk) begin
    if (!rst_n) sq_v_r[0] <= 1'b0;
    else if (ce) sq_v_r[0] <= v0_r;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      sq_s_r[0]    <= sqx_r + sqy_r + sqz_r;
      sq_root_r[0] <= '0;
      sq_rem_r[0]  <= '0;
      sq_vec_r[0]  <= vec0_r;
      sq_side_r[0] <= side0_r;
    end
  end

  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
    logic [RM_W+1:0] rem_sh;
    logic [RM_W+1:0] trial;
    logic            ge;

    always_comb begin
      rem_sh = {sq_rem_r[j], sq_s_r[j][S_W-1:S_W-2]};
      trial  = (RM_W+2)'({sq_root_r[j], 2'b01});
      ge     = (rem_sh >= trial);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) sq_v_r[j+1] <= 1'b0;
      else if (ce) sq_v_r[j+1] <= sq_v_r[j];
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        sq_s_r[j+1]    <= sq_s_r[j] << 2;
        sq_root_r[j+1] <= {sq_root_r[j][R_W-2:0], ge};
        sq_rem_r[j+1]  <= ge ? RM_W'(rem_sh - trial) : RM_W'(rem_sh);
        sq_vec_r[j+1]  <= sq_vec_r[j];
        sq_side_r[j+1] <= sq_side_r[j];
      end
    end
  end

  // divide stages
  logic             dv_v_r    [0:Q_W];
  logic [R_W-1:0]   dv_len_r  [0:Q_W];
  logic [DV_W-1:0]  dv_rem_r  [0:Q_W][3];
  logic [Q_W-1:0]   dv_q_r    [0:Q_W][3];
  logic [2:0]       dv_neg_r  [0:Q_W];
  pfs_side_t        dv_side_r [0:Q_W];

  logic signed [T_W-1:0] ln [3];
  logic [T_W-1:0]        mg [3];

  always_comb begin
    ln[0] = sq_vec_r[SQRT_STEPS].x;
    ln[1] = sq_vec_r[SQRT_STEPS].y;
    ln[2] = sq_vec_r[SQRT_STEPS].z;
    for (int k = 0; k < 3; k++) begin
      mg[k] = ln[k][T_W-1] ? (~ln[k] + 1'b1) : ln[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) dv_v_r[0] <= 1'b0;
    else if (ce) dv_v_r[0] <= sq_v_r[SQRT_STEPS];
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      dv_len_r[0]  <= sq_root_r[SQRT_STEPS];
      dv_side_r[0] <= sq_side_r[SQRT_STEPS];
      for (int k = 0; k < 3; k++) begin
        dv_rem_r[0][k] <= {mg[k], {Q14_SH{1'b0}}};
        dv_q_r[0][k]   <= '0;
        dv_neg_r[0][k] <= ln[k][T_W-1];
      end
    end
  end

  for (genvar j = 0; j < Q_W; j++) begin : g_div
    logic [DV_W-1:0] dvs;
    logic [DV_W-1:0] rem_n [3];
    logic [Q_W-1:0]  q_n   [3];

    always_comb begin
      dvs = DV_W'(dv_len_r[j]) << (Q_W - 1 - j);
      for (int k = 0; k < 3; k++) begin
        rem_n[k] = dv_rem_r[j][k];
        q_n[k]   = dv_q_r[j][k];
        if (dv_rem_r[j][k] >= dvs) begin
          rem_n[k]             = dv_rem_r[j][k] - dvs;
          q_n[k][Q_W - 1 - j]  = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) dv_v_r[j+1] <= 1'b0;
      else if (ce) dv_v_r[j+1] <= dv_v_r[j];
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        dv_len_r[j+1]  <= dv_len_r[j];
        dv_neg_r[j+1]  <= dv_neg_r[j];
        dv_side_r[j+1] <= dv_side_r[j];
        for (int k = 0; k < 3; k++) begin
          dv_rem_r[j+1][k] <= rem_n[k];
          dv_q_r[j+1][k]   <= q_n[k];
        end
      end
    end
  end

  // apply sign, clamp to 1.0, zero length gives the zero vector
  logic [Q_W-1:0]        qf [3];
  logic [N_W-1:0]        qe [3];
  logic signed [N_W-1:0] res [3];
  logic                  v_out_r;
  pfs_nvec_t             vec_out_r;
  pfs_side_t             side_out_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      qf[k] = dv_q_r[Q_W][k];
      if (dv_len_r[Q_W] == '0) begin
        qf[k] = '0;
      end else if (qf[k] > Q_W'(ONE_Q14)) begin
        qf[k] = Q_W'(ONE_Q14);
      end
      qe[k]  = {1'b0, qf[k]};
      res[k] = dv_neg_r[Q_W][k] ? $signed(-qe[k]) : $signed(qe[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v_out_r <= 1'b0;
    else if (ce) v_out_r <= dv_v_r[Q_W];
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      vec_out_r.x <= res[0];
      vec_out_r.y <= res[1];
      vec_out_r.z <= res[2];
      side_out_r  <= dv_side_r[Q_W];
    end
  end

  assign out_valid = v_out_r;
  assign out_vec   = vec_out_r;
  assign out_side  = side_out_r;

endmodule

/* src/pfs_back.sv */
// Back part: normalizes the normal, lights it, reflects, raises the specular
// term and forms the colors. Depends on pfs_pkg and pfs_norm.
module pfs_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  output logic                pop,
  input  pfs_pkg::pfs_fq_t    q_data,
  input  pfs_pkg::pfs_light_t light,
  output logic                out_valid,
  input  logic                out_stall,
  output pfs_pkg::pfs_out_t   out_data
);
  import pfs_pkg::*;

  logic      ce;
  logic      out_valid_r;
  pfs_out_t  out_r;

  // whole pipeline moves while the output register is free or transfers
  assign ce        = !out_valid_r || !out_stall;
  assign pop       = ce && !q_empty;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  logic signed [15:0] lx, ly, lz;
  assign lx = light[0];
  assign ly = light[1];
  assign lz = light[2];

  // normalize the transformed normal
  logic      n1_v;
  pfs_nvec_t n1_vec;
  pfs_side_t n1_side;

  pfs_norm u_norm_n (
    .clk       (clk),
    .rst_n     (rst_n),
    .ce        (ce),
    .in_valid  (pop),
    .in_vec    (q_data.vec),
    .in_side   (q_data.side),
    .out_valid (n1_v),
    .out_vec   (n1_vec),
    .out_side  (n1_side)
  );

  // n.l products, then sum and floor-shift
  logic               b1_v_r, b2_v_r, b3_v_r, b4_v_r;
  pfs_nvec_t          b1_n_r, b2_n_r;
  pfs_side_t          b1_side_r, b2_side_r, b3_side_r, b4_side_r;
  pfs_side_t          b1_side_d;
  logic signed [31:0] dp [3];
  logic signed [31:0] dp_r [3];
  logic signed [31:0] dsum;
  logic signed [D_W-1:0] d;
  logic signed [D_W-1:0] d_r;
  logic signed [33:0] rp [3];
  logic signed [33:0] rp_r [3];
  logic signed [T_W-1:0] rv [3];
  pfs_tvec_t          rv_r;

  always_comb begin
    dp[0] = n1_vec.x * lx;
    dp[1] = n1_vec.y * ly;
    dp[2] = n1_vec.z * lz;
    dsum  = dp_r[0] + dp_r[1] + dp_r[2];
    d     = dsum[31:Q14_SH];
    // clamp the diffuse term at zero
    b1_side_d      = b1_side_r;
    b1_side_d.diff = d[D_W-1] ? '0 : d;
    rp[0] = d_r * b2_n_r.x;
    rp[1] = d_r * b2_n_r.y;
    rp[2] = d_r * b2_n_r.z;
    // floor(2*d*n / 2^14) - l
    rv[0] = $signed(rp_r[0][33:Q14_SH-1]) - lx;
    rv[1] = $signed(rp_r[1][33:Q14_SH-1]) - ly;
    rv[2] = $signed(rp_r[2][33:Q14_SH-1]) - lz;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_v_r <= 1'b0;
      b2_v_r <= 1'b0;
      b3_v_r <= 1'b0;
      b4_v_r <= 1'b0;
    end else if (ce) begin
      b1_v_r <= n1_v;
      b2_v_r <= b1_v_r;
      b3_v_r <= b2_v_r;
      b4_v_r <= b3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      dp_r      <= dp;
      b1_n_r    <= n1_vec;
      b1_side_r <= n1_side;
      d_r       <= d;
      b2_n_r    <= b1_n_r;
      b2_side_r <= b1_side_d;
      rp_r      <= rp;
      b3_side_r <= b2_side_r;
      rv_r.x    <= rv[0];
      rv_r.y    <= rv[1];
      rv_r.z    <= rv[2];
      b4_side_r <= b3_side_r;
    end
  end

  // normalize the reflection
  logic      n2_v;
  pfs_nvec_t n2_vec;
  pfs_side_t n2_side;

  pfs_norm u_norm_r (
    .clk       (clk),
    .rst_n     (rst_n),
    .ce        (ce),
    .in_valid  (b4_v_r),
    .in_vec    (rv_r),
    .in_side   (b4_side_r),
    .out_valid (n2_v),
    .out_vec   (n2_vec),
    .out_side  (n2_side)
  );

  // specular power: one truncating multiply per stage, skipped past exponent
  logic             pw_v_r    [0:POW_STEPS];
  logic [ACC_W-1:0] pw_acc_r  [0:POW_STEPS];
  logic [ACC_W-1:0] pw_base_r [0:POW_STEPS];
  pfs_side_t        pw_side_r [0:POW_STEPS];

  always_ff @(posedge clk) begin
    if (!rst_n) pw_v_r[0] <= 1'b0;
    else if (ce) pw_v_r[0] <= n2_v;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      pw_acc_r[0]  <= ACC_W'(ONE_Q14);
      pw_base_r[0] <= n2_vec.z[N_W-1] ? '0 : n2_vec.z[ACC_W-1:0];
      pw_side_r[0] <= n2_side;
    end
  end

  for (genvar k = 0; k < POW_STEPS; k++) begin : g_pow
    logic [2*ACC_W-1:0] pr;

    always_comb begin
      pr = pw_acc_r[k] * pw_base_r[k];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) pw_v_r[k+1] <= 1'b0;
      else if (ce) pw_v_r[k+1] <= pw_v_r[k];
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        pw_acc_r[k+1]  <= (EXP_W'(k) < pw_side_r[k].expo) ?
                          pr[ACC_W+Q14_SH-1:Q14_SH] : pw_acc_r[k];
        pw_base_r[k+1] <= pw_base_r[k];
        pw_side_r[k+1] <= pw_side_r[k];
      end
    end
  end

  // weight the specular term and add the diffuse term
  logic [ACC_W+13:0] s6p;
  logic [SUM_W-1:0]  sum_r;
  logic              s_v_r;
  pfs_side_t         s_side_r;

  always_comb begin
    s6p = pw_acc_r[POW_STEPS] * 14'(SPEC_W_Q14);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s_v_r <= 1'b0;
    else if (ce) s_v_r <= pw_v_r[POW_STEPS];
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      sum_r    <= SUM_W'(pw_side_r[POW_STEPS].diff) + SUM_W'(s6p[ACC_W+13:Q14_SH]);
      s_side_r <= pw_side_r[POW_STEPS];
    end
  end

  // scale each channel, add ambient, saturate
  logic [8+SUM_W-1:0] cp [3];
  logic [13:0]        cv [3];
  logic [7:0]         ch [3];

  always_comb begin
    cp[0] = s_side_r.red   * sum_r;
    cp[1] = s_side_r.green * sum_r;
    cp[2] = s_side_r.blue  * sum_r;
    for (int i = 0; i < 3; i++) begin
      cv[i] = 14'(cp[i][8+SUM_W-1:Q14_SH]) + 14'(AMBIENT);
      ch[i] = (cv[i] > 14'(CH_MAX)) ? 8'(CH_MAX) : cv[i][7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (ce) out_valid_r <= s_v_r;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      out_r.out_red   <= ch[0];
      out_r.out_green <= ch[1];
      out_r.out_blue  <= ch[2];
    end
  end

endmodule

/* tb/tb.sv */
// Testbench for phong_fragment_shade_core: random and directed fragments
// with a scoreboard that predicts each shaded pixel. Depends on pfs_pkg.
`timescale 1ns / 1ps

import pfs_pkg::*;

// Holds the shading registers and the pixels still owed by the core.
class shade_scoreboard;
  logic [63:0] mat_row [3];
  logic [47:0] light;
  pfs_out_t    owed_pixels [$];
  int          errors;
  int          checked;

  function void load_reset();
    mat_row[0] = 64'd4096;
    mat_row[1] = 64'd4096 << 16;
    mat_row[2] = 64'd4096 << 32;
    light      = 48'd16384 << 32;
  endfunction

  function void set_reg(pfs_cfg_idx_t idx, logic [63:0] value);
    case (idx)
      CFG_ROW0:  mat_row[0] = value;
      CFG_ROW1:  mat_row[1] = value;
      CFG_ROW2:  mat_row[2] = value;
      CFG_LIGHT: light = value[47:0];
      default: ;
    endcase
  endfunction

  static function longint lane_of(logic [63:0] word, int k);
    return longint'($signed(word[16*k +: 16]));
  endfunction

  static function longint unsigned int_sqrt(longint unsigned s);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > s) bitv >>= 2;
    while (bitv != 0) begin
      if (s >= root + bitv) begin
        s -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  // Scale to unit length in Q1.14; a zero vector stays zero.
  static function void unitize(input longint v [3], output longint u [3]);
    longint unsigned s;
    longint len, q;
    s = 0;
    for (int i = 0; i < 3; i++) s += longint'(v[i] * v[i]);
    len = longint'(int_sqrt(s));
    for (int i = 0; i < 3; i++) begin
      q = (len != 0) ? (v[i] * ONE_Q14) / len : 0;
      if (q > ONE_Q14) q = ONE_Q14;
      if (q < -ONE_Q14) q = -ONE_Q14;
      u[i] = q;
    end
  endfunction

  function pfs_out_t shade_fragment(pfs_in_t f);
    longint nin [3], t [3], n [3], l [3], rv [3], r [3];
    longint acc26, dot, d, diffv, base, acc, s6, total, ch;
    logic [7:0] col [3];
    pfs_out_t px;
    nin[0] = f.normal_x;
    nin[1] = f.normal_y;
    nin[2] = f.normal_z;
    col[0] = f.diffuse_red;
    col[1] = f.diffuse_green;
    col[2] = f.diffuse_blue;
    for (int i = 0; i < 3; i++) l[i] = lane_of({16'd0, light}, i);
    // transform the normal with w = 1
    for (int i = 0; i < 3; i++) begin
      acc26 = lane_of(mat_row[i], 3) * ONE_Q14;
      for (int j = 0; j < 3; j++) acc26 += lane_of(mat_row[i], j) * nin[j];
      t[i] = acc26 >>> 12;
    end
    unitize(t, n);
    dot = 0;
    for (int i = 0; i < 3; i++) dot += n[i] * l[i];
    d = dot >>> 14;
    diffv = (d > 0) ? d : 0;
    // reflect the light about the normal
    for (int i = 0; i < 3; i++) rv[i] = ((2 * d * n[i]) >>> 14) - l[i];
    unitize(rv, r);
    base = (r[2] > 0) ? r[2] : 0;
    acc = ONE_Q14;
    for (int k = 0; k < f.spec_exponent; k++) acc = (acc * base) >> 14;
    s6 = (acc * SPEC_W_Q14) >> 14;
    total = diffv + s6;
    for (int i = 0; i < 3; i++) begin
      ch = AMBIENT + ((longint'(col[i]) * total) >> 14);
      if (ch > CH_MAX) ch = CH_MAX;
      col[i] = ch[7:0];
    end
    px.out_red = col[0];
    px.out_green = col[1];
    px.out_blue = col[2];
    return px;
  endfunction

  function void note_fragment(pfs_in_t f);
    owed_pixels.push_back(shade_fragment(f));
  endfunction

  function void check_pixel(pfs_out_t got);
    pfs_out_t exp_px;
    if (owed_pixels.size() == 0) begin
      $display("%0t: unexpected pixel %h", $realtime, got);
      errors++;
      return;
    end
    exp_px = owed_pixels.pop_front();
    checked++;
    if (got.out_red !== exp_px.out_red)
      $display("%0t: red expected %0d actual %0d", $realtime, exp_px.out_red, got.out_red);
    if (got.out_green !== exp_px.out_green)
      $display("%0t: green expected %0d actual %0d", $realtime, exp_px.out_green,
               got.out_green);
    if (got.out_blue !== exp_px.out_blue)
      $display("%0t: blue expected %0d actual %0d", $realtime, exp_px.out_blue,
               got.out_blue);
    if (got !== exp_px) errors++;
  endfunction
endclass

module tb;
  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  pfs_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  pfs_out_t out_data;
  logic     cfg_valid;
  logic     cfg_ready;
  logic [1:0]  cfg_index;
  logic [63:0] cfg_data;

  shade_scoreboard sb;
  bit calm;
  bit hold_out;
  int sent;

  phong_fragment_shade_core u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("Test completed with failures");
    $finish;
  end

  // Track every transfer on the three channels
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.set_reg(pfs_cfg_idx_t'(cfg_index), cfg_data);
      if (in_valid && !in_stall) sb.note_fragment(in_data);
      if (out_valid && !out_stall) sb.check_pixel(out_data);
    end
  end

  // Receiver: random stall runs, no stalls when calm, or one long hold when asked
  initial begin
    int len;
    forever begin
      if (hold_out) begin
        out_stall <= 1'b1;
        repeat (600) @(posedge clk);
        hold_out = 0;
      end else if (calm) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 3);
        out_stall <= ($urandom_range(0, 99) < 30);
        repeat (len) @(posedge clk);
      end
    end
  end

  // Present one register write and hold it until transfer
  task automatic write_reg(pfs_cfg_idx_t idx, logic [63:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Offer one fragment, hold it until transfer, then, unless calm, sometimes idle a random gap
  task automatic send_fragment(pfs_in_t f);
    int gap;
    in_valid <= 1'b1;
    in_data  <= f;
    do @(posedge clk); while (in_stall);
    sent++;
    gap = 0;
    if (!calm && $urandom_range(0, 99) < 40)
      gap = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic [15:0] rand_q14();
    case ($urandom_range(0, 9))
      0:       return 16'($urandom);
      1:       return 16'h8000;
      default: return 16'($signed($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  function automatic logic [15:0] rand_q12();
    case ($urandom_range(0, 7))
      0:       return 16'($urandom);
      1:       return 16'd0;
      default: return 16'($signed($urandom_range(0, 16384)) - 8192);
    endcase
  endfunction

  function automatic pfs_in_t rand_fragment();
    pfs_in_t f;
    f.normal_x = rand_q14();
    f.normal_y = rand_q14();
    f.normal_z = rand_q14();
    f.diffuse_red = 8'($urandom);
    f.diffuse_green = 8'($urandom);
    f.diffuse_blue = 8'($urandom);
    f.spec_exponent = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 16));
    return f;
  endfunction

  function automatic pfs_in_t make_fragment(logic [15:0] x, logic [15:0] y, logic [15:0] z,
                                            logic [7:0] c, logic [7:0] e);
    pfs_in_t f;
    f.normal_x = x;
    f.normal_y = y;
    f.normal_z = z;
    f.diffuse_red = c;
    f.diffuse_green = ~c;
    f.diffuse_blue = c;
    f.spec_exponent = e;
    return f;
  endfunction

  // Drop the input, then wait until every owed pixel has come out
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.owed_pixels.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic load_matrix(logic [63:0] r0, logic [63:0] r1, logic [63:0] r2,
                             logic [63:0] lv);
    wait_idle();
    write_reg(CFG_ROW0, r0);
    write_reg(CFG_ROW1, r1);
    write_reg(CFG_ROW2, r2);
    write_reg(CFG_LIGHT, lv);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [63:0] rand_row();
    return {rand_q12(), rand_q12(), rand_q12(), rand_q12()};
  endfunction

  task automatic run_random(int count);
    repeat (count) send_fragment(rand_fragment());
  endtask

  initial begin
    sb = new();
    sb.load_reset();
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_ROW0;
    cfg_data <= '0;
    calm = 0;
    hold_out = 0;
    sent = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed fragments under the reset matrix and light
    send_fragment(make_fragment(16'd0, 16'd0, 16'd16384, 8'd255, 8'd0));
    send_fragment(make_fragment(16'd0, 16'd0, 16'd16384, 8'd255, 8'd255));
    send_fragment(make_fragment(16'd0, 16'd0, 16'd0, 8'd200, 8'd0));
    send_fragment(make_fragment(16'd0, 16'd0, 16'd0, 8'd200, 8'd7));
    send_fragment(make_fragment(16'h8000, 16'h8000, 16'h8000, 8'd255, 8'd1));
    send_fragment(make_fragment(16'h7fff, 16'h7fff, 16'h7fff, 8'd0, 8'd255));
    send_fragment(make_fragment(16'd0, 16'd0, -16'sd16384, 8'd128, 8'd3));
    send_fragment(make_fragment(16'd16384, 16'd0, 16'd0, 8'd255, 8'd0));
    send_fragment(make_fragment(16'd11585, 16'd0, 16'd11585, 8'd255, 8'd2));
    send_fragment(make_fragment(-16'sd16384, 16'd16384, 16'd0, 8'd64, 8'd128));
    send_fragment(make_fragment(16'hffff, 16'h0001, 16'h4000, 8'd1, 8'd16));
    send_fragment(make_fragment(16'd0, 16'd0, 16'd16384, 8'd0, 8'd0));
    // Zero matrix: every normal collapses to zero length
    load_matrix(64'd0, 64'd0, 64'd0, 48'd16384 << 32);
    send_fragment(make_fragment(16'd100, 16'd200, 16'd300, 8'd255, 8'd0));
    send_fragment(make_fragment(16'd100, 16'd200, 16'd300, 8'd255, 8'd9));
    // Light that is far from unit length saturates the channels
    load_matrix(64'd4096, 64'd4096 << 16, 64'd4096 << 32, 48'h7fff_7fff_7fff);
    send_fragment(make_fragment(16'd9459, 16'd9459, 16'd9459, 8'd255, 8'd1));
    send_fragment(make_fragment(16'd0, 16'd0, 16'd16384, 8'd100, 8'd0));
    load_matrix(64'hffff_ffff_ffff_ffff, 64'h8000_8000_8000_8000, 64'h7fff_7fff_7fff_7fff,
                48'h8000_8000_8000);
    send_fragment(make_fragment(16'h8000, 16'h7fff, 16'h0, 8'd255, 8'd0));
    send_fragment(make_fragment(16'h7fff, 16'h8000, 16'hffff, 8'd255, 8'd255));

    // Random phases over several register settings
    load_matrix(64'd4096, 64'd4096 << 16, 64'd4096 << 32, 48'd16384 << 32);
    run_random(250);
    for (int ph = 0; ph < 6; ph++) begin
      load_matrix(rand_row(), rand_row(), rand_row(),
                  {rand_q14(), rand_q14(), rand_q14()});
      calm = (ph == 2);
      if (ph == 3) begin
        // Back up the core: long receiver hold while fragments keep coming
        calm = 1;
        hold_out = 1;
      end
      run_random(230);
      calm = 0;
    end
    load_matrix(64'hffff_ffff_ffff_ffff, 64'h8000_8000_8000_8000, 64'h7fff_7fff_7fff_7fff,
                48'hffff_ffff_ffff);
    run_random(200);
    wait_idle();

    $display("Shaded %0d fragments, checked %0d pixels over twelve register settings.",
             sent, sb.checked);
    if (sb.errors == 0 && sb.owed_pixels.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end
endmodule

/* filelist.f */
src/pfs_pkg.sv
src/pfs_fifo.sv
src/pfs_front.sv
src/pfs_norm.sv
src/pfs_back.sv
src/phong_fragment_shade_core.sv
tb/tb.sv
